// File: rtl/qpv_pkg.sv
package qpv_pkg;

    localparam int unsigned WIN_W       = 16;
    localparam int unsigned WSTEP_W     = 24;
    localparam int unsigned VEL_W       = 21;
    localparam int unsigned REL_OUT_W   = 8;
    localparam int unsigned POS_OUT_W   = 32;
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned MS_PER_S_W  = 10;
    localparam int unsigned QUO_W       = 33;
    localparam int unsigned DIV_STEPS   = QUO_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [WIN_W-1:0]   WIN_RESET   = 16'd256;
    localparam logic [WIN_W-1:0]   ELAPSED_MAX = 16'hFFFF;
    localparam logic [QUO_W-1:0]   VEL_POS_LIM = 33'd1048575;
    localparam logic [QUO_W-1:0]   VEL_NEG_LIM = 33'd1048576;
    localparam logic [VEL_W-1:0]   VEL_MAX     = 21'h0FFFFF;
    localparam logic [VEL_W-1:0]   VEL_MIN     = 21'h100000;

    typedef enum logic {
        KIND_PIN  = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic div_last;
    } t_dp_sts;

endpackage

// File: rtl/qpv_ctrl.sv
module qpv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output qpv_pkg::t_dp_cmd o_cmd,
    input  qpv_pkg::t_dp_sts i_sts
);
    import qpv_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.close ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output phases overlap");

    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("divider end not followed by finish");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_FIN))
        else $error("result raised from wrong state");

endmodule

// File: rtl/qpv_dp.sv
module qpv_dp #(
    parameter int unsigned STEPS_PER_REV = 256,
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [qpv_pkg::WIN_W-1:0]               i_cfg_wr_data,
    input  logic                                    i_kind,
    input  logic                                    i_level_a,
    input  logic                                    i_level_b,
    input  qpv_pkg::t_dp_cmd                        i_cmd,
    output qpv_pkg::t_dp_sts                        o_sts,
    output logic signed [qpv_pkg::POS_OUT_W-1:0]    o_position,
    output logic [qpv_pkg::REL_OUT_W-1:0]           o_relative_position,
    output logic signed [qpv_pkg::VEL_W-1:0]        o_velocity,
    output logic                                    o_velocity_updated
);
    import qpv_pkg::*;

    localparam int unsigned REL_W = $clog2(STEPS_PER_REV);
    localparam logic [REL_W-1:0] REL_TOP = REL_W'(STEPS_PER_REV - 1);
    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};
    localparam logic signed [WSTEP_W-1:0] WSTEP_MAX = {1'b0, {(WSTEP_W-1){1'b1}}};
    localparam logic signed [WSTEP_W-1:0] WSTEP_MIN = {1'b1, {(WSTEP_W-1){1'b0}}};

    logic [WIN_W-1:0]                r_window_ms;
    t_kind                           r_kind;
    logic                            r_a;
    logic                            r_b;
    logic                            r_last_a;
    logic                            r_primed;
    logic signed [POSITION_BITS-1:0] r_pos;
    logic [REL_W-1:0]                r_rel;
    logic signed [WSTEP_W-1:0]       r_wsteps;
    logic [WIN_W-1:0]                r_elapsed;
    logic signed [VEL_W-1:0]         r_speed;
    logic                            r_updated;
    logic                            r_neg;
    logic [WSTEP_W-1:0]              r_mag;
    logic [WIN_W-1:0]                r_divisor;
    logic [QUO_W-1:0]                r_quo;
    logic [WIN_W-1:0]                r_rem;
    logic [DIV_CNT_W-1:0]            r_cnt;

    logic [WIN_W-1:0]  n_elapsed;
    logic              close;
    logic              step_up;
    logic              step_dn;
    logic [WIN_W:0]    rem_sh;
    logic              rem_ge;
    logic [QUO_W-1:0]  quo_neg;

    assign n_elapsed = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign close     = (r_kind == KIND_TICK) && (n_elapsed >= r_window_ms);
    assign step_up   = (r_kind == KIND_PIN) && r_primed && r_a && !r_last_a && !r_b;
    assign step_dn   = (r_kind == KIND_PIN) && r_primed && r_a && !r_last_a && r_b;
    assign rem_sh    = {r_rem, r_quo[QUO_W-1]};
    assign rem_ge    = (rem_sh >= {1'b0, r_divisor});
    assign quo_neg   = QUO_W'(-r_quo);

    assign o_sts.close    = close;
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= WIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_window_ms <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_a    <= i_level_a;
            r_b    <= i_level_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a  <= 1'b0;
            r_primed  <= 1'b0;
            r_pos     <= '0;
            r_rel     <= '0;
            r_wsteps  <= '0;
            r_elapsed <= '0;
            r_speed   <= '0;
            r_updated <= 1'b0;
        end else if (i_cmd.exec) begin
            if (r_kind == KIND_PIN) begin
                r_updated <= 1'b0;
                r_primed  <= 1'b1;
                r_last_a  <= r_a;
                if (step_up) begin
                    if (r_pos != POS_MAX) begin
                        r_pos <= r_pos + 1'b1;
                        r_rel <= (r_rel == REL_TOP) ? '0 : r_rel + 1'b1;
                    end
                    if (r_wsteps != WSTEP_MAX) begin
                        r_wsteps <= r_wsteps + 1'b1;
                    end
                end else if (step_dn) begin
                    if (r_pos != POS_MIN) begin
                        r_pos <= r_pos - 1'b1;
                        r_rel <= (r_rel == '0) ? REL_TOP : r_rel - 1'b1;
                    end
                    if (r_wsteps != WSTEP_MIN) begin
                        r_wsteps <= r_wsteps - 1'b1;
                    end
                end
            end else if (close) begin
                r_updated <= 1'b1;
                r_wsteps  <= '0;
                r_elapsed <= '0;
            end else begin
                r_updated <= 1'b0;
                r_elapsed <= n_elapsed;
            end
        end else if (i_cmd.finish) begin
            if (r_neg) begin
                r_speed <= (r_quo > VEL_NEG_LIM) ? VEL_MIN : quo_neg[VEL_W-1:0];
            end else begin
                r_speed <= (r_quo > VEL_POS_LIM) ? VEL_MAX : r_quo[VEL_W-1:0];
            end
        end
    end

    // divider operands and shift-subtract iteration
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && close) begin
            r_neg     <= r_wsteps[WSTEP_W-1];
            r_mag     <= r_wsteps[WSTEP_W-1] ? WSTEP_W'(-r_wsteps) : r_wsteps;
            r_divisor <= n_elapsed;
        end
        if (i_cmd.mul) begin
            r_quo <= QUO_W'(r_mag * MS_PER_S_W'(MS_PER_S));
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            r_rem <= rem_ge ? WIN_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[WIN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_position          = POS_OUT_W'(r_pos);
    assign o_relative_position = REL_OUT_W'(r_rel);
    assign o_velocity          = r_speed;
    assign o_velocity_updated  = r_updated;

    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel <= REL_TOP)
        else $error("relative position out of range");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && close) |=> (r_elapsed == '0 && r_wsteps == '0 && r_updated))
        else $error("window close did not restart the window");

endmodule

// File: rtl/quadrature_position_velocity_core.sv
// Sequence: a pin event or a tick that does not close the window goes through the
// execute state and is then offered at the output; a tick that closes the window passes
// through execute, a multiply step, the 33-step shift-subtract speed divider and finish.
// A new transaction is accepted only once the previous result has been taken.
// Reset (synchronous, active low): position, window and speed clear, window length 256.
module quadrature_position_velocity_core #(
    parameter int unsigned STEPS_PER_REV = 256,
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [qpv_pkg::WIN_W-1:0]               i_cfg_wr_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_kind,
    input  logic                                    i_level_a,
    input  logic                                    i_level_b,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [qpv_pkg::POS_OUT_W-1:0]    o_position,
    output logic [qpv_pkg::REL_OUT_W-1:0]           o_relative_position,
    output logic signed [qpv_pkg::VEL_W-1:0]        o_velocity,
    output logic                                    o_velocity_updated
);
    import qpv_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    qpv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    qpv_dp #(
        .STEPS_PER_REV (STEPS_PER_REV),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_kind              (i_kind),
        .i_level_a           (i_level_a),
        .i_level_b           (i_level_b),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_position          (o_position),
        .o_relative_position (o_relative_position),
        .o_velocity          (o_velocity),
        .o_velocity_updated  (o_velocity_updated)
    );

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpv_pkg::*;

    localparam int STEPS_PER_REV = 256;
    localparam int POSITION_BITS = 32;
    localparam longint POS_HI = (64'sd1 <<< (POSITION_BITS - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;
    localparam int WSUM_HI = (1 << (WSTEP_W - 1)) - 1;
    localparam int WSUM_LO = -WSUM_HI - 1;
    localparam longint VEL_HI = (64'sd1 <<< (VEL_W - 1)) - 1;
    localparam longint VEL_LO = -VEL_HI - 1;
    localparam int ELAPSED_CAP = (1 << WIN_W) - 1;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic signed [POS_OUT_W-1:0] position;
        logic [REL_OUT_W-1:0]        rel_pos;
        logic signed [VEL_W-1:0]     velocity;
        logic                        vel_fresh;
    } t_reading;

    typedef struct packed {
        logic                        is_cfg;
        logic [WIN_W-1:0]            cfg_val;
        t_kind                       kind;
        logic                        a;
        logic                        b;
        logic                        known;
        logic signed [POS_OUT_W-1:0] pos;
        logic [REL_OUT_W-1:0]        rel;
        logic signed [VEL_W-1:0]     vel;
        logic                        upd;
    } t_row;

    localparam t_row DIRECTED [0:22] = '{
        '{0, 0,     KIND_PIN,  1, 1, 1,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  1, 0, 1,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  0, 0, 1,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  1, 0, 1,  1,   1,    0, 0},
        '{0, 0,     KIND_PIN,  0, 1, 1,  1,   1,    0, 0},
        '{0, 0,     KIND_PIN,  1, 1, 1,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  0, 1, 1,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  1, 1, 1, -1, 255,    0, 0},
        '{0, 0,     KIND_TICK, 1, 1, 1, -1, 255,    0, 0},
        '{1, 1,     KIND_PIN,  0, 0, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_TICK, 0, 0, 1, -1, 255, -500, 1},
        '{0, 0,     KIND_PIN,  0, 0, 1, -1, 255, -500, 0},
        '{0, 0,     KIND_PIN,  1, 0, 1,  0,   0, -500, 0},
        '{0, 0,     KIND_TICK, 1, 0, 1,  0,   0, 1000, 1},
        '{1, 0,     KIND_PIN,  0, 0, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_TICK, 0, 1, 1,  0,   0,    0, 1},
        '{1, 65535, KIND_PIN,  0, 0, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_TICK, 1, 1, 1,  0,   0,    0, 0},
        '{1, 3,     KIND_PIN,  0, 0, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  0, 1, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_PIN,  1, 1, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_TICK, 0, 0, 0,  0,   0,    0, 0},
        '{0, 0,     KIND_TICK, 1, 0, 1, -1, 255, -333, 1}
    };

    localparam logic [WIN_W-1:0] WINDOW_PLAN [0:6] = '{1, 2, 5, 12, 0, 7, 3};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [WIN_W-1:0] i_cfg_wr_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_kind = 1'b0;
    logic i_level_a = 1'b0;
    logic i_level_b = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [POS_OUT_W-1:0] o_position;
    logic [REL_OUT_W-1:0] o_relative_position;
    logic signed [VEL_W-1:0] o_velocity;
    logic o_velocity_updated;

    logic enc_primed = 1'b0;
    logic enc_last_a = 1'b0;
    longint enc_pos = 0;
    int win_sum = 0;
    int win_elapsed = 0;
    longint speed_sps = 0;
    logic [WIN_W-1:0] win_len = WIN_RESET;

    t_reading pending_readings [$];
    int fault_count = 0;
    int cycle_count = 0;
    int tx_gap_max = 4;
    int rx_gap_max = 4;
    bit rx_hold_req = 1'b0;
    logic pin_a = 1'b0;
    logic roam_down = 1'b0;

    quadrature_position_velocity_core #(
        .STEPS_PER_REV(STEPS_PER_REV),
        .POSITION_BITS(POSITION_BITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_level_a          (i_level_a),
        .i_level_b          (i_level_b),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_position         (o_position),
        .o_relative_position(o_relative_position),
        .o_velocity         (o_velocity),
        .o_velocity_updated (o_velocity_updated)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_reading track_encoder(t_kind kind, logic a, logic b);
        t_reading r;
        longint spd;
        longint rel;
        r.vel_fresh = 1'b0;
        if (kind == KIND_PIN) begin
            if (!enc_primed) begin
                enc_primed = 1'b1;
            end else if (a && !enc_last_a) begin
                if (b) begin
                    if (enc_pos > POS_LO) enc_pos--;
                    if (win_sum > WSUM_LO) win_sum--;
                end else begin
                    if (enc_pos < POS_HI) enc_pos++;
                    if (win_sum < WSUM_HI) win_sum++;
                end
            end
            enc_last_a = a;
        end else begin
            if (win_elapsed < ELAPSED_CAP) win_elapsed++;
            if (win_elapsed >= win_len) begin
                spd = (longint'(win_sum) * longint'(MS_PER_S)) / longint'(win_elapsed);
                if (spd > VEL_HI) spd = VEL_HI;
                if (spd < VEL_LO) spd = VEL_LO;
                speed_sps = spd;
                win_sum = 0;
                win_elapsed = 0;
                r.vel_fresh = 1'b1;
            end
        end
        rel = enc_pos % longint'(STEPS_PER_REV);
        if (rel < 0) rel += STEPS_PER_REV;
        r.position = enc_pos[POS_OUT_W-1:0];
        r.rel_pos = rel[REL_OUT_W-1:0];
        r.velocity = speed_sps[VEL_W-1:0];
        return r;
    endfunction

    task automatic offer_event(t_kind kind, logic a, logic b, t_reading want);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pending_readings.push_back(want);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_level_a <= a;
        i_level_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_readings();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_window(logic [WIN_W-1:0] ms);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= ms;
        win_len = ms;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic roam_encoder(int count, int tick_pct);
        int roll;
        t_kind k;
        logic a;
        logic b;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct) begin
                k = KIND_TICK;
                a = $urandom_range(0, 1);
                b = $urandom_range(0, 1);
            end else if (roll < tick_pct + 10) begin
                k = KIND_PIN;
                a = $urandom_range(0, 1);
                b = $urandom_range(0, 1);
            end else begin
                if ($urandom_range(0, 19) == 0) roam_down = ~roam_down;
                k = KIND_PIN;
                a = ~pin_a;
                b = roam_down;
            end
            if (k == KIND_PIN) pin_a = a;
            offer_event(k, a, b, track_encoder(k, a, b));
        end
    endtask

    task automatic spin_steps(int steps, logic down);
        for (int n = 0; n < steps; n++) begin
            offer_event(KIND_PIN, 1'b0, down, track_encoder(KIND_PIN, 1'b0, down));
            offer_event(KIND_PIN, 1'b1, down, track_encoder(KIND_PIN, 1'b1, down));
        end
        pin_a = 1'b1;
    endtask

    task automatic check_reading();
        t_reading got;
        t_reading want;
        got = '{o_position, o_relative_position, o_velocity, o_velocity_updated};
        if (pending_readings.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected reading pos %0d rel %0d vel %0d upd %0b",
                     $time, got.position, got.rel_pos, got.velocity, got.vel_fresh);
        end else begin
            want = pending_readings.pop_front();
            if (got !== want) begin
                fault_count++;
                $display({"%0t: reading mismatch, expected pos %0d rel %0d vel %0d upd %0b,",
                          " got pos %0d rel %0d vel %0d upd %0b"}, $time,
                         want.position, want.rel_pos, want.velocity, want.vel_fresh,
                         got.position, got.rel_pos, got.velocity, got.vel_fresh);
            end
        end
    endtask

    initial begin : rx_side
        int wait_n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            wait_n = $urandom_range(0, rx_gap_max);
            if (wait_n > 0) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            check_reading();
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_reading r;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].is_cfg) begin
                drain_readings();
                set_window(DIRECTED[i].cfg_val);
            end else begin
                r = track_encoder(DIRECTED[i].kind, DIRECTED[i].a, DIRECTED[i].b);
                if (DIRECTED[i].known)
                    r = '{DIRECTED[i].pos, DIRECTED[i].rel, DIRECTED[i].vel, DIRECTED[i].upd};
                if (DIRECTED[i].kind == KIND_PIN) pin_a = DIRECTED[i].a;
                offer_event(DIRECTED[i].kind, DIRECTED[i].a, DIRECTED[i].b, r);
            end
        end

        for (int p = 0; p < $size(WINDOW_PLAN); p++) begin
            drain_readings();
            set_window(WINDOW_PLAN[p]);
            tx_gap_max = (p % 3 == 1) ? 0 : 4;
            rx_gap_max = (p % 3 == 2) ? 0 : 4;
            if (p == 3) rx_hold_req = 1'b1;
            roam_encoder(80, 25);
        end

        // push a burst of steps each way into one-millisecond windows
        drain_readings();
        set_window(1);
        tx_gap_max = 0;
        rx_gap_max = 1;
        spin_steps(10, 1'b0);
        offer_event(KIND_TICK, 1'b0, 1'b1, track_encoder(KIND_TICK, 1'b0, 1'b1));
        spin_steps(10, 1'b1);
        offer_event(KIND_TICK, 1'b1, 1'b0, track_encoder(KIND_TICK, 1'b1, 1'b0));

        drain_readings();
        repeat (40) @(negedge i_clk);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
